/* rtl/pcrt_pkg.sv */
`timescale 1ns / 1ps
// Package for the pending command retry table.
// Sizes, codes, command and entry types. No dependencies.
package pcrt_pkg;
	localparam int ENTRIES    = 16;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int DATA_BYTES = 8;
	localparam int LEN_W      = 4;
	localparam int DATA_W     = 64;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_STORE   = 2'd0,
		MODE_CONFIRM = 2'd1,
		MODE_UNAVAIL = 2'd2,
		MODE_TIMEOUT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_ONOFF = 2'd0,
		KIND_LEVEL = 2'd1,
		KIND_COLOR = 2'd2,
		KIND_DP    = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RETRY_BUDGET = 2'd0,
		CFG_TIMEOUT      = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_SCAN,
		B_EMIT
	} back_state_t;

	typedef struct packed {
		mode_t              mode;
		logic [15:0]        addr;
		logic [7:0]         endpoint;
		logic [1:0]         kind;
		logic [15:0]        param_a;
		logic [15:0]        param_b;
		logic [15:0]        transition;
		logic [DATA_W-1:0]  data;
		logic [LEN_W-1:0]   pay_len;
		logic [31:0]        now;
	} cmd_t;

	typedef struct packed {
		logic [15:0]        addr;
		logic [7:0]         endpoint;
		logic [1:0]         kind;
		logic [15:0]        param_a;
		logic [15:0]        param_b;
		logic [15:0]        transition;
		logic [DATA_W-1:0]  data;
		logic [LEN_W-1:0]   pay_len;
		logic [3:0]         retries;
		logic [31:0]        stamp;
	} entry_t;
endpackage

/* rtl/pcrt_if.sv */
`timescale 1ns / 1ps
// Channel interfaces of the pending command retry table: request,
// result and configuration write. No dependencies.
interface pcrt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] addr;
	logic [7:0]  endpoint;
	logic [1:0]  kind;
	logic [15:0] param_a;
	logic [15:0] param_b;
	logic [15:0] transition;
	logic [63:0] data_bytes;
	logic [7:0]  pay_len;
	logic [31:0] now;
	modport source (output valid, mode, addr, endpoint, kind, param_a, param_b,
		transition, data_bytes, pay_len, now, input ready);
	modport sink (input valid, mode, addr, endpoint, kind, param_a, param_b,
		transition, data_bytes, pay_len, now, output ready);
endinterface

interface pcrt_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_addr;
	logic [7:0]  out_endpoint;
	logic [1:0]  out_kind;
	logic [15:0] out_param_a;
	logic [15:0] out_param_b;
	logic [15:0] out_transition;
	logic [63:0] out_data;
	logic [3:0]  out_pay_len;
	logic        cause;
	logic        last;
	modport source (output valid, out_addr, out_endpoint, out_kind, out_param_a,
		out_param_b, out_transition, out_data, out_pay_len, cause, last,
		input ready);
	modport sink (input valid, out_addr, out_endpoint, out_kind, out_param_a,
		out_param_b, out_transition, out_data, out_pay_len, cause, last,
		output ready);
endinterface

interface pcrt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/pcrt_front.sv */
`timescale 1ns / 1ps
// Front stage: accepts requests and normalizes store fields by kind.
// Depends on pcrt_pkg and pcrt_in_if.
module pcrt_front (
	input  logic          clk,
	input  logic          arst_n,
	pcrt_in_if.sink       req,
	output pcrt_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_ready
);
	import pcrt_pkg::*;

	cmd_t             n;
	cmd_t             cmd_s1;
	logic             v_s1;
	logic [LEN_W-1:0] len_sat;

	assign req.ready = !v_s1 || cmd_ready;
	assign cmd       = cmd_s1;
	assign cmd_valid = v_s1;

	always_comb begin
		if (req.pay_len > 8'(DATA_BYTES)) begin
			len_sat = LEN_W'(DATA_BYTES);
		end else begin
			len_sat = req.pay_len[LEN_W-1:0];
		end
		n            = '0;
		n.mode       = mode_t'(req.mode);
		n.addr       = req.addr;
		n.endpoint   = req.endpoint;
		n.kind       = req.kind;
		n.now        = req.now;
		case (kind_t'(req.kind))
			KIND_ONOFF: begin
				n.param_a = {15'd0, (req.param_a != 16'd0)};
			end
			KIND_LEVEL: begin
				n.param_a    = {8'd0, req.param_a[7:0]};
				n.transition = req.transition;
			end
			KIND_COLOR: begin
				n.param_a    = req.param_a;
				n.param_b    = req.param_b;
				n.transition = req.transition;
			end
			KIND_DP: begin
				n.param_a  = {8'd0, req.param_a[7:0]};
				n.param_b  = {8'd0, req.param_b[7:0]};
				n.pay_len  = len_sat;
				for (int b = 0; b < DATA_W / 8; b++) begin
					n.data[8*b +: 8] = (LEN_W'(b) < len_sat) ? req.data_bytes[8*b +: 8] : 8'd0;
				end
			end
			default: begin
				n.param_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1 <= n;
		end
	end
endmodule

/* rtl/pcrt_queue.sv */
`timescale 1ns / 1ps
// Short command queue between front and back.
// Depends on pcrt_pkg.
module pcrt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  pcrt_pkg::cmd_t in_cmd,
	input  logic           in_valid,
	output logic           in_ready,
	output pcrt_pkg::cmd_t out_cmd,
	output logic           out_valid,
	input  logic           out_ready
);
	import pcrt_pkg::*;

	cmd_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	logic              pop;

	assign in_ready  = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign out_valid = cnt_q != '0;
	assign out_cmd   = mem[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= in_cmd;
		end
	end
endmodule

/* rtl/pcrt_back.sv */
`timescale 1ns / 1ps
// Back end: entry table, slot choice, stamp scan, retry emitter and
// configuration registers. Depends on pcrt_pkg and pcrt_if.
module pcrt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pcrt_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	pcrt_cfg_if.sink       cfg,
	pcrt_out_if.source     rsp
);
	import pcrt_pkg::*;

	function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

	back_state_t        state_q, state_d;
	cmd_t               cmd_q;
	entry_t             e_q [ENTRIES];
	logic [ENTRIES-1:0] active_q, active_d;
	logic [3:0]         budget_q;
	logic [31:0]        timeout_q;
	logic [ENTRIES-1:0] pend_q, pend_d;
	logic               cause_q, cause_d;
	logic [IDX_W-1:0]   idx_q, best_q;
	logic [31:0]        bstamp_q;
	logic               rsp_valid_q;

	logic [ENTRIES-1:0] match_vec, aged_vec, retry_vec, pend_rest, clr;
	logic [IDX_W-1:0]   match_idx, free_idx, pend_sel, wr_slot, scan_best;
	logic               match_any, free_any, out_free, cand_lt;
	logic               wr_en, emit, scan_start, scan_step;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = active_q[i] && (e_q[i].addr == cmd_q.addr);
			aged_vec[i]  = active_q[i] && ((cmd_q.now - e_q[i].stamp) >= timeout_q);
			retry_vec[i] = e_q[i].retries != 4'd0;
		end
	end

	assign match_any = |match_vec;
	assign match_idx = first_set(match_vec);
	assign free_any  = ~&active_q;
	assign free_idx  = first_set(~active_q);
	assign pend_sel  = first_set(pend_q);
	assign pend_rest = pend_q & ~(ENTRIES'(1) << pend_sel);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign cand_lt   = e_q[idx_q].stamp < bstamp_q;
	assign scan_best = cand_lt ? idx_q : best_q;
	assign cmd_ready = state_q == B_IDLE;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;

	always_comb begin
		state_d    = state_q;
		wr_en      = 1'b0;
		wr_slot    = match_idx;
		clr        = '0;
		pend_d     = pend_q;
		cause_d    = cause_q;
		emit       = 1'b0;
		scan_start = 1'b0;
		scan_step  = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) state_d = B_EXEC;
			end
			B_EXEC: begin
				state_d = B_IDLE;
				case (cmd_q.mode)
					MODE_STORE: begin
						if (match_any) begin
							wr_en = 1'b1;
						end else if (free_any) begin
							wr_en   = 1'b1;
							wr_slot = free_idx;
						end else begin
							scan_start = 1'b1;
							state_d    = B_SCAN;
						end
					end
					MODE_CONFIRM: begin
						if (match_any) clr = ENTRIES'(1) << match_idx;
					end
					MODE_UNAVAIL: begin
						if (match_any) begin
							clr = ENTRIES'(1) << match_idx;
							if (retry_vec[match_idx]) begin
								pend_d  = ENTRIES'(1) << match_idx;
								cause_d = 1'b0;
								state_d = B_EMIT;
							end
						end
					end
					MODE_TIMEOUT: begin
						clr     = aged_vec;
						pend_d  = aged_vec & retry_vec;
						cause_d = 1'b1;
						if (|(aged_vec & retry_vec)) state_d = B_EMIT;
					end
					default: begin
						state_d = B_IDLE;
					end
				endcase
			end
			B_SCAN: begin
				scan_step = 1'b1;
				if (idx_q == IDX_W'(ENTRIES - 1)) begin
					wr_en   = 1'b1;
					wr_slot = scan_best;
					state_d = B_IDLE;
				end
			end
			B_EMIT: begin
				if (out_free) begin
					emit   = 1'b1;
					pend_d = pend_rest;
					if (pend_rest == '0) state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_comb begin
		active_d = active_q & ~clr;
		if (wr_en) active_d[wr_slot] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			active_q    <= '0;
			pend_q      <= '0;
			cause_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			budget_q    <= 4'd1;
			timeout_q   <= 32'd5000;
		end else begin
			state_q  <= state_d;
			pend_q   <= pend_d;
			cause_q  <= cause_d;
			active_q <= active_d;
			if (emit) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			if (cfg.valid) begin
				case (cfg_idx_t'(cfg.index))
					CFG_RETRY_BUDGET: budget_q  <= cfg.data[3:0];
					CFG_TIMEOUT:      timeout_q <= cfg.data;
					default:          budget_q  <= budget_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && cmd_valid) cmd_q <= cmd;
		if (wr_en) begin
			e_q[wr_slot] <= '{addr: cmd_q.addr, endpoint: cmd_q.endpoint, kind: cmd_q.kind,
				param_a: cmd_q.param_a, param_b: cmd_q.param_b,
				transition: cmd_q.transition, data: cmd_q.data,
				pay_len: cmd_q.pay_len, retries: budget_q, stamp: cmd_q.now};
		end
		if (scan_start) begin
			idx_q    <= IDX_W'(1);
			best_q   <= '0;
			bstamp_q <= e_q[0].stamp;
		end else if (scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (cand_lt) begin
				best_q   <= idx_q;
				bstamp_q <= e_q[idx_q].stamp;
			end
		end
		if (emit) begin
			rsp.out_addr       <= e_q[pend_sel].addr;
			rsp.out_endpoint   <= e_q[pend_sel].endpoint;
			rsp.out_kind       <= e_q[pend_sel].kind;
			rsp.out_param_a    <= e_q[pend_sel].param_a;
			rsp.out_param_b    <= e_q[pend_sel].param_b;
			rsp.out_transition <= e_q[pend_sel].transition;
			rsp.out_data       <= e_q[pend_sel].data;
			rsp.out_pay_len    <= e_q[pend_sel].pay_len;
			rsp.cause          <= cause_q;
			rsp.last           <= pend_rest == '0;
		end
	end
endmodule

/* rtl/pending_command_retry_table.sv */
`timescale 1ns / 1ps
// Top level of the pending command retry table.
// Depends on pcrt_pkg, pcrt_if, pcrt_front, pcrt_queue, pcrt_back.
//
// A request passes a register stage and a two-deep queue, then the table
// engine fetches it into a command register and executes it. A store with
// no matching and no free entry then runs the serial oldest-stamp scan.
// Unavailable and timeout requests give their retry results one at a time
// through the single output register as the sink frees it; a timeout check
// gives up to ENTRIES results. Configuration writes are taken every cycle.
module pending_command_retry_table (
	input  logic      clk,
	input  logic      arst_n,
	pcrt_in_if.sink   req,
	pcrt_out_if.source rsp,
	pcrt_cfg_if.sink  cfg
);
	import pcrt_pkg::*;

	cmd_t f_cmd, q_cmd;
	logic f_valid, f_ready, q_valid, q_ready;

	pcrt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (f_cmd),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready)
	);

	pcrt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (f_cmd),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.out_cmd   (q_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready)
	);

	pcrt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cfg       (cfg),
		.rsp       (rsp)
	);
endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench of pending_command_retry_table: directed and random requests
// checked against a behavioral table model held in a scoreboard class.
// Depends on pcrt_pkg, pcrt_if and the RTL of the block.
module tb;
	import pcrt_pkg::*;

	typedef struct {
		mode_t       mode;
		logic [15:0] addr;
		logic [7:0]  endpoint;
		kind_t       kind;
		logic [15:0] param_a;
		logic [15:0] param_b;
		logic [15:0] transition;
		logic [63:0] data_bytes;
		logic [7:0]  pay_len;
		logic [31:0] now;
	} request_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  endpoint;
		logic [1:0]  kind;
		logic [15:0] param_a;
		logic [15:0] param_b;
		logic [15:0] transition;
		logic [63:0] data;
		logic [3:0]  pay_len;
		logic        cause;
		logic        last;
	} resend_t;

	class retry_scoreboard;
		bit          active[ENTRIES];
		resend_t     slot[ENTRIES];
		logic [3:0]  retries[ENTRIES];
		logic [31:0] stamp[ENTRIES];
		logic [3:0]  budget = 4'd1;
		logic [31:0] timeout = 32'd5000;
		resend_t     resend_q[$];
		int          errors = 0;

		function void configure(cfg_idx_t idx, logic [31:0] value);
			if (idx == CFG_RETRY_BUDGET)
				budget = value[3:0];
			else if (idx == CFG_TIMEOUT)
				timeout = value;
		endfunction

		function int outstanding();
			return resend_q.size();
		endfunction

		function void resend(int i, bit cause);
			resend_t r;
			r = slot[i];
			r.cause = cause;
			r.last = 1'b0;
			retries[i] = retries[i] - 4'd1;
			resend_q.push_back(r);
		endfunction

		function void store(request_t q);
			int          s;
			int          free_s;
			int          old_s;
			logic [3:0]  len;
			logic [63:0] mask;
			resend_t     e;
			s = -1;
			free_s = -1;
			old_s = -1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (active[i]) begin
					if (s < 0 && slot[i].addr == q.addr)
						s = i;
					if (old_s < 0 || stamp[i] < stamp[old_s])
						old_s = i;
				end else if (free_s < 0) begin
					free_s = i;
				end
			end
			if (s < 0)
				s = (free_s >= 0) ? free_s : old_s;
			e = '0;
			e.addr = q.addr;
			e.endpoint = q.endpoint;
			e.kind = q.kind;
			case (q.kind)
				KIND_ONOFF: e.param_a = (q.param_a != 0) ? 16'd1 : 16'd0;
				KIND_LEVEL: begin
					e.param_a = {8'd0, q.param_a[7:0]};
					e.transition = q.transition;
				end
				KIND_COLOR: begin
					e.param_a = q.param_a;
					e.param_b = q.param_b;
					e.transition = q.transition;
				end
				default: begin
					len = (q.pay_len > DATA_BYTES) ? 4'(DATA_BYTES) : q.pay_len[3:0];
					mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
					e.param_a = {8'd0, q.param_a[7:0]};
					e.param_b = {8'd0, q.param_b[7:0]};
					e.data = q.data_bytes & mask;
					e.pay_len = len;
				end
			endcase
			slot[s] = e;
			retries[s] = budget;
			stamp[s] = q.now;
			active[s] = 1'b1;
		endfunction

		function void note_request(request_t q);
			int n;
			n = resend_q.size();
			case (q.mode)
				MODE_STORE: store(q);
				MODE_CONFIRM:
					for (int i = 0; i < ENTRIES; i++)
						if (active[i] && slot[i].addr == q.addr) begin
							active[i] = 1'b0;
							break;
						end
				MODE_UNAVAIL:
					for (int i = 0; i < ENTRIES; i++)
						if (active[i] && slot[i].addr == q.addr) begin
							if (retries[i] > 0)
								resend(i, 1'b0);
							active[i] = 1'b0;
							break;
						end
				default:
					for (int i = 0; i < ENTRIES; i++)
						if (active[i] && (q.now - stamp[i]) >= timeout) begin
							if (retries[i] > 0)
								resend(i, 1'b1);
							active[i] = 1'b0;
						end
			endcase
			if (resend_q.size() > n)
				resend_q[resend_q.size() - 1].last = 1'b1;
		endfunction

		function void check_result(resend_t got);
			resend_t want;
			if (resend_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, got);
				return;
			end
			want = resend_q.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: mismatch expected %p actual %p", $time, want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   idle_pct = 27;
	int   hold_req = 0;
	int   hold_cnt = 0;
	logic [31:0] tick = 32'd0;
	logic [15:0] addr_pool[24];
	retry_scoreboard sb = new();

	pcrt_in_if  req_if();
	pcrt_out_if rsp_if();
	pcrt_cfg_if cfg_if();

	pending_command_retry_table dut (
		.clk(clk), .arst_n(arst_n), .req(req_if), .rsp(rsp_if), .cfg(cfg_if)
	);

	always #6 clk = ~clk;

	initial begin
		#10ms;
		$display("tb NOT OK");
		$finish;
	end

	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	always @(posedge clk)
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_result({rsp_if.out_addr, rsp_if.out_endpoint, rsp_if.out_kind,
				rsp_if.out_param_a, rsp_if.out_param_b, rsp_if.out_transition,
				rsp_if.out_data, rsp_if.out_pay_len, rsp_if.cause, rsp_if.last});

	task automatic send_request(request_t q);
		int gap;
		gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.mode <= q.mode;
		req_if.addr <= q.addr;
		req_if.endpoint <= q.endpoint;
		req_if.kind <= q.kind;
		req_if.param_a <= q.param_a;
		req_if.param_b <= q.param_b;
		req_if.transition <= q.transition;
		req_if.data_bytes <= q.data_bytes;
		req_if.pay_len <= q.pay_len;
		req_if.now <= q.now;
		forever begin
			@(posedge clk);
			if (req_if.ready)
				break;
		end
		sb.note_request(q);
	endtask

	task automatic drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		forever begin
			@(posedge clk);
			if (cfg_if.ready)
				break;
		end
		sb.configure(idx, value);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_config(logic [3:0] budget, logic [31:0] timeout);
		drain();
		write_reg(CFG_RETRY_BUDGET, {28'd0, budget});
		write_reg(CFG_TIMEOUT, timeout);
	endtask

	function automatic request_t make_request(mode_t m, logic [15:0] a, kind_t k,
			logic [15:0] pa, logic [63:0] d, logic [7:0] len, logic [31:0] now);
		request_t q;
		q.mode = m;
		q.addr = a;
		q.endpoint = 8'hA5;
		q.kind = k;
		q.param_a = pa;
		q.param_b = ~pa;
		q.transition = pa ^ 16'h5A5A;
		q.data_bytes = d;
		q.pay_len = len;
		q.now = now;
		return q;
	endfunction

	function automatic request_t random_request();
		request_t q;
		int pick;
		pick = $urandom_range(0, 99);
		q.mode = mode_t'((pick < 50) ? MODE_STORE : (pick < 65) ? MODE_CONFIRM :
			(pick < 80) ? MODE_UNAVAIL : MODE_TIMEOUT);
		q.addr = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, 23)]
			: 16'($urandom);
		q.endpoint = 8'($urandom);
		q.kind = kind_t'($urandom_range(0, 3));
		q.param_a = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
		q.param_b = 16'($urandom);
		q.transition = 16'($urandom);
		q.data_bytes = {$urandom, $urandom};
		q.pay_len = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8))
			: 8'($urandom);
		tick += $urandom_range(0, 1500);
		q.now = ($urandom_range(0, 19) == 0) ? $urandom : tick;
		return q;
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++)
			send_request(random_request());
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.mode = MODE_STORE;
		req_if.addr = '0;
		req_if.endpoint = '0;
		req_if.kind = KIND_ONOFF;
		req_if.param_a = '0;
		req_if.param_b = '0;
		req_if.transition = '0;
		req_if.data_bytes = '0;
		req_if.pay_len = '0;
		req_if.now = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_RETRY_BUDGET;
		cfg_if.data = '0;
		for (int i = 0; i < 24; i++)
			addr_pool[i] = 16'($urandom);
		addr_pool[0] = 16'h0000;
		addr_pool[1] = 16'hFFFF;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// kinds and field extremes
		send_request(make_request(MODE_STORE, 16'h0001, KIND_ONOFF, 16'h0000, '1, 8'd8, 0));
		send_request(make_request(MODE_STORE, 16'h0002, KIND_ONOFF, 16'h8000, '1, 8'd8, 0));
		send_request(make_request(MODE_STORE, 16'h0003, KIND_LEVEL, 16'hFFFF, '1, 8'd0, 0));
		send_request(make_request(MODE_STORE, 16'h0004, KIND_COLOR, 16'hFFFF, '1, 8'd3, 0));
		send_request(make_request(MODE_STORE, 16'h0005, KIND_DP, 16'hFFFF, '1, 8'd0, 0));
		send_request(make_request(MODE_STORE, 16'h0006, KIND_DP, 16'h1234, '1, 8'd3, 0));
		send_request(make_request(MODE_STORE, 16'h0007, KIND_DP, 16'hFFFF, '1, 8'd8, 0));
		send_request(make_request(MODE_STORE, 16'hFFFF, KIND_DP, 16'hFFFF, '1, 8'd255, 0));
		send_request(make_request(MODE_STORE, 16'h0002, KIND_COLOR, 16'h0000, '0, 8'd0, 1));
		send_request(make_request(MODE_UNAVAIL, 16'h0003, KIND_ONOFF, 0, 0, 0, 2));
		send_request(make_request(MODE_UNAVAIL, 16'h0003, KIND_ONOFF, 0, 0, 0, 2));
		send_request(make_request(MODE_CONFIRM, 16'h0004, KIND_ONOFF, 0, 0, 0, 3));
		send_request(make_request(MODE_CONFIRM, 16'h0004, KIND_ONOFF, 0, 0, 0, 3));
		send_request(make_request(MODE_TIMEOUT, 16'h0000, KIND_ONOFF, 0, 0, 0, 4999));
		send_request(make_request(MODE_TIMEOUT, 16'h0000, KIND_ONOFF, 0, 0, 0, 6000));
		// full table at the largest stamp, eviction on tie, wrapped ages
		for (int i = 0; i < ENTRIES; i++)
			send_request(make_request(MODE_STORE, 16'(16'h1000 + i), kind_t'(i % 4),
				16'(i), '1, 8'(i), 32'hFFFF_FFFF));
		send_request(make_request(MODE_STORE, 16'hFFFF, KIND_LEVEL, 16'h00FF, 0, 0,
			32'hFFFF_FFFF));
		send_request(make_request(MODE_TIMEOUT, 0, KIND_ONOFF, 0, 0, 0, 32'hFFFF_FFFF));
		send_request(make_request(MODE_TIMEOUT, 0, KIND_ONOFF, 0, 0, 0, 32'h0000_1387));

		set_config(4'd3, 32'd2000);
		random_phase(120);
		set_config(4'd0, 32'd0);
		random_phase(40);
		set_config(4'd15, 32'hFFFF_FFFF);
		idle_pct = 0;
		random_phase(60);
		idle_pct = 27;
		set_config(4'd2, 32'd800);
		hold_req = 400;
		random_phase(80);
		drain();
		random_phase(70);
		set_config(4'd1, 32'd5000);
		random_phase(60);

		drain();
		if (sb.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
